// ===== src/e2r_pkg.sv =====
// shared constants, types and arithmetic helpers of the euler to rotation matrix block
package e2r_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 14;
	localparam int FIELD_W    = 16;
	localparam int SW         = FRAC_BITS + 2;
	localparam int SIN_LAT    = 9;
	localparam int LAT        = SIN_LAT + 3;

	localparam logic [31:0] PC1  = 32'd1686629713;
	localparam logic [31:0] PC3  = 32'd693598668;
	localparam logic [31:0] PC5  = 32'd85569306;
	localparam logic [31:0] PC7  = 32'd5026995;
	localparam logic [31:0] PC9  = 32'd172272;
	localparam logic [31:0] PC11 = 32'd3864;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [31:0] QUARTER = 32'h4000_0000;

	typedef logic signed [SW-1:0] trig_t;
	typedef logic signed [SW:0]   acc_t;
	typedef logic [FIELD_W-1:0]   field_t;

	// one horner step in q30: c - (u * p) >> 30
	function automatic logic [31:0] horner(input logic [30:0] u, input logic [31:0] p,
			input logic [31:0] c);
		logic [62:0] prod;
		prod = 63'(u) * 63'(p);
		return c - prod[61:30];
	endfunction

	// rounded fixed-point product, floor of (a*b + half) / one
	function automatic trig_t fx_mul(input trig_t a, input trig_t b);
		logic signed [2*SW-1:0] prod;
		prod = (2*SW)'(a) * (2*SW)'(b);
		prod = prod + ((2*SW)'(1) <<< (FRAC_BITS - 1));
		return trig_t'(prod >>> FRAC_BITS);
	endfunction

	// clamp to +-one and fit into the output field
	function automatic field_t sat_out(input acc_t v);
		acc_t lim;
		logic signed [31:0] w;
		lim = acc_t'(1) <<< FRAC_BITS;
		w = 32'(v);
		if (v > lim) begin
			w = 32'(lim);
		end else if (v < -lim) begin
			w = 32'(-lim);
		end
		return w[FIELD_W-1:0];
	endfunction

endpackage

// ===== src/e2r_if.sv =====
// valid/ready channels for angle items and matrix items
interface e2r_angle_if import e2r_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [FIELD_W-1:0] roll_angle;
	logic signed [FIELD_W-1:0] pitch_angle;
	logic signed [FIELD_W-1:0] yaw_angle;
	modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2r_matrix_if import e2r_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [FIELD_W-1:0] m00;
	logic signed [FIELD_W-1:0] m01;
	logic signed [FIELD_W-1:0] m02;
	logic signed [FIELD_W-1:0] m10;
	logic signed [FIELD_W-1:0] m11;
	logic signed [FIELD_W-1:0] m12;
	logic signed [FIELD_W-1:0] m20;
	logic signed [FIELD_W-1:0] m21;
	logic signed [FIELD_W-1:0] m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// ===== src/e2r_sin.sv =====
// pipelined fixed-point sine of a 32-bit phase, odd polynomial in q30
module e2r_sin import e2r_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] phase,
	output trig_t       sin_val
);
	logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6, quad_s7, quad_s8;
	logic [30:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic [30:0] u_s2, u_s3, u_s4, u_s5, u_s6;
	logic [31:0] p_s3, p_s4, p_s5, p_s6, p_s7;
	logic [32:0] s_s8;
	logic [61:0] tt;
	logic [62:0] tp;
	logic [33:0] rnd;
	logic [33:0] mag;
	trig_t       sin_s9;

	assign tt  = 62'(t_s1) * 62'(t_s1);
	assign tp  = 63'(t_s7) * 63'(p_s7);
	assign rnd = 34'(s_s8) + (34'(1) << (29 - FRAC_BITS));

	always_comb begin
		mag = rnd >> (30 - FRAC_BITS);
		if (mag > (34'(1) << FRAC_BITS)) begin
			mag = 34'(1) << FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= phase[31:30];
			t_s1    <= phase[30] ? Q30_ONE - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
			quad_s2 <= quad_s1;
			t_s2    <= t_s1;
			u_s2    <= tt[60:30];
			quad_s3 <= quad_s2;
			t_s3    <= t_s2;
			u_s3    <= u_s2;
			p_s3    <= horner(u_s2, PC11, PC9);
			quad_s4 <= quad_s3;
			t_s4    <= t_s3;
			u_s4    <= u_s3;
			p_s4    <= horner(u_s3, p_s3, PC7);
			quad_s5 <= quad_s4;
			t_s5    <= t_s4;
			u_s5    <= u_s4;
			p_s5    <= horner(u_s4, p_s4, PC5);
			quad_s6 <= quad_s5;
			t_s6    <= t_s5;
			u_s6    <= u_s5;
			p_s6    <= horner(u_s5, p_s5, PC3);
			quad_s7 <= quad_s6;
			t_s7    <= t_s6;
			p_s7    <= horner(u_s6, p_s6, PC1);
			quad_s8 <= quad_s7;
			s_s8    <= tp[62:30];
			sin_s9  <= quad_s8[1] ? -trig_t'(mag) : trig_t'(mag);
		end
	end

	assign sin_val = sin_s9;
endmodule

// ===== src/euler_to_rotation_matrix.sv =====
// Euler angles (roll, pitch, yaw as binary angles, full circle 2^16) to the
// z-y-x rotation matrix in signed q14, saturated to +-1.0. Fully pipelined:
// one item per cycle while the result side does not stall; from accept to
// result an item passes the polynomial sine units, the product registers and
// the sums into the output register. A stall on the result side freezes the whole pipeline.
module euler_to_rotation_matrix import e2r_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	e2r_angle_if.sink    angles,
	e2r_matrix_if.source matrix
);
	logic           en;
	logic [LAT-1:0] vld_q;
	logic [31:0]    ph_r, ph_p, ph_y;
	trig_t          sr, cr, sp, cp, sy, cy;
	trig_t          spsr_s10, spcr_s10, cycp_s10, sycp_s10, cpsr_s10, cpcr_s10;
	trig_t          sycr_s10, sysr_s10, cycr_s10, cysr_s10, sp_s10, cy_s10, sy_s10;
	trig_t          cyspsr_s11, cyspcr_s11, syspsr_s11, syspcr_s11;
	trig_t          cycp_s11, sycp_s11, cpsr_s11, cpcr_s11, sycr_s11, sysr_s11;
	trig_t          cycr_s11, cysr_s11, sp_s11;
	field_t         m00_s12, m01_s12, m02_s12, m10_s12, m11_s12, m12_s12;
	field_t         m20_s12, m21_s12, m22_s12;

	assign en = !vld_q[LAT-1] || matrix.ready;
	assign angles.ready = en;

	assign ph_r = 32'(32'(unsigned'(angles.roll_angle)) << (32 - ANGLE_BITS));
	assign ph_p = 32'(32'(unsigned'(angles.pitch_angle)) << (32 - ANGLE_BITS));
	assign ph_y = 32'(32'(unsigned'(angles.yaw_angle)) << (32 - ANGLE_BITS));

	e2r_sin u_sr (.clk, .en, .phase(ph_r),           .sin_val(sr));
	e2r_sin u_cr (.clk, .en, .phase(ph_r + QUARTER), .sin_val(cr));
	e2r_sin u_sp (.clk, .en, .phase(ph_p),           .sin_val(sp));
	e2r_sin u_cp (.clk, .en, .phase(ph_p + QUARTER), .sin_val(cp));
	e2r_sin u_sy (.clk, .en, .phase(ph_y),           .sin_val(sy));
	e2r_sin u_cy (.clk, .en, .phase(ph_y + QUARTER), .sin_val(cy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], angles.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spsr_s10   <= fx_mul(sp, sr);
			spcr_s10   <= fx_mul(sp, cr);
			cycp_s10   <= fx_mul(cy, cp);
			sycp_s10   <= fx_mul(sy, cp);
			cpsr_s10   <= fx_mul(cp, sr);
			cpcr_s10   <= fx_mul(cp, cr);
			sycr_s10   <= fx_mul(sy, cr);
			sysr_s10   <= fx_mul(sy, sr);
			cycr_s10   <= fx_mul(cy, cr);
			cysr_s10   <= fx_mul(cy, sr);
			sp_s10     <= sp;
			cy_s10     <= cy;
			sy_s10     <= sy;
			cyspsr_s11 <= fx_mul(cy_s10, spsr_s10);
			cyspcr_s11 <= fx_mul(cy_s10, spcr_s10);
			syspsr_s11 <= fx_mul(sy_s10, spsr_s10);
			syspcr_s11 <= fx_mul(sy_s10, spcr_s10);
			cycp_s11   <= cycp_s10;
			sycp_s11   <= sycp_s10;
			cpsr_s11   <= cpsr_s10;
			cpcr_s11   <= cpcr_s10;
			sycr_s11   <= sycr_s10;
			sysr_s11   <= sysr_s10;
			cycr_s11   <= cycr_s10;
			cysr_s11   <= cysr_s10;
			sp_s11     <= sp_s10;
			m00_s12    <= sat_out(acc_t'(cycp_s11));
			m01_s12    <= sat_out(acc_t'(cyspsr_s11) - acc_t'(sycr_s11));
			m02_s12    <= sat_out(acc_t'(cyspcr_s11) + acc_t'(sysr_s11));
			m10_s12    <= sat_out(acc_t'(sycp_s11));
			m11_s12    <= sat_out(acc_t'(syspsr_s11) + acc_t'(cycr_s11));
			m12_s12    <= sat_out(acc_t'(syspcr_s11) - acc_t'(cysr_s11));
			m20_s12    <= sat_out(acc_t'(0) - acc_t'(sp_s11));
			m21_s12    <= sat_out(acc_t'(cpsr_s11));
			m22_s12    <= sat_out(acc_t'(cpcr_s11));
		end
	end

	assign matrix.valid = vld_q[LAT-1];
	assign matrix.m00   = m00_s12;
	assign matrix.m01   = m01_s12;
	assign matrix.m02   = m02_s12;
	assign matrix.m10   = m10_s12;
	assign matrix.m11   = m11_s12;
	assign matrix.m12   = m12_s12;
	assign matrix.m20   = m20_s12;
	assign matrix.m21   = m21_s12;
	assign matrix.m22   = m22_s12;

`ifndef NO_ASSERTIONS
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		angles.ready == (!matrix.valid || matrix.ready))
		else $error("input ready does not follow output stall");
	a_stall_freezes_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!angles.ready |=> $stable(vld_q))
		else $error("pipeline valids moved during stall");
	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		(matrix.valid && !matrix.ready) |=> (matrix.valid && $stable(matrix.m11)))
		else $error("stalled item changed");
`endif
endmodule

// ===== bench/tb.sv =====
// testbench of the euler angle to rotation matrix block: corner and random items against a predictor
module tb;
	import e2r_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] roll;
		logic [15:0] pitch;
		logic [15:0] yaw;
	} angles_t;

	typedef struct packed {
		logic [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;
	int checked = 0;
	angles_t pending[$];
	matrix_t expected[$];
	int burst = 0;
	int gap = 0;
	int stall_mode = 0;
	int stall_cnt = 0;

	e2r_angle_if angles ();
	e2r_matrix_if matrix ();

	euler_to_rotation_matrix dut (
		.clk(clk),
		.arst_n(arst_n),
		.angles(angles.sink),
		.matrix(matrix.source)
	);

	always #5 clk = ~clk;

	function automatic longint quarter_sine(longint unsigned t);
		longint unsigned u, p;
		u = (t * t) >> 30;
		p = 3864;
		p = 172272 - ((u * p) >> 30);
		p = 5026995 - ((u * p) >> 30);
		p = 85569306 - ((u * p) >> 30);
		p = 693598668 - ((u * p) >> 30);
		p = 1686629713 - ((u * p) >> 30);
		return longint'((t * p) >> 30);
	endfunction

	function automatic longint sine_q14(logic [31:0] phase);
		longint unsigned t, r;
		t = phase[29:0];
		if (phase[30])
			t = 64'd1073741824 - t;
		r = (quarter_sine(t) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		if (r > (64'd1 << FRAC_BITS))
			r = 64'd1 << FRAC_BITS;
		return phase[31] ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint mul_q14(longint a, longint b);
		return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic logic [15:0] clamp_q14(longint v);
		longint lim;
		lim = 64'sd1 <<< FRAC_BITS;
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return v[15:0];
	endfunction

	function automatic matrix_t rotation_of(angles_t a);
		logic [31:0] pr, pp, py;
		longint sr, cr, sp, cp, sy, cy, spsr, spcr;
		matrix_t m;
		pr = {a.roll, 16'h0};
		pp = {a.pitch, 16'h0};
		py = {a.yaw, 16'h0};
		sr = sine_q14(pr);
		cr = sine_q14(pr + QUARTER);
		sp = sine_q14(pp);
		cp = sine_q14(pp + QUARTER);
		sy = sine_q14(py);
		cy = sine_q14(py + QUARTER);
		spsr = mul_q14(sp, sr);
		spcr = mul_q14(sp, cr);
		m.m00 = clamp_q14(mul_q14(cy, cp));
		m.m01 = clamp_q14(mul_q14(cy, spsr) - mul_q14(sy, cr));
		m.m02 = clamp_q14(mul_q14(cy, spcr) + mul_q14(sy, sr));
		m.m10 = clamp_q14(mul_q14(sy, cp));
		m.m11 = clamp_q14(mul_q14(sy, spsr) + mul_q14(cy, cr));
		m.m12 = clamp_q14(mul_q14(sy, spcr) - mul_q14(cy, sr));
		m.m20 = clamp_q14(-sp);
		m.m21 = clamp_q14(mul_q14(cp, sr));
		m.m22 = clamp_q14(mul_q14(cp, cr));
		return m;
	endfunction

	function automatic logic [15:0] pick_angle();
		logic [15:0] special[10] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'h7fff,
			16'hffff, 16'h0001, 16'h3fff, 16'h4001, 16'hbfff};
		if ($urandom_range(0, 5) == 0)
			return special[$urandom_range(0, 9)];
		return 16'($urandom);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angles.valid <= 1'b0;
			angles.roll_angle <= '0;
			angles.pitch_angle <= '0;
			angles.yaw_angle <= '0;
			burst <= 0;
			gap <= 0;
		end else begin
			if (angles.valid && angles.ready) begin
				expected.insert(expected.size(), rotation_of({angles.roll_angle,
					angles.pitch_angle, angles.yaw_angle}));
				void'(pending.pop_front());
			end
			if (!angles.valid || angles.ready) begin
				if (gap > 0) begin
					gap <= gap - 1;
					angles.valid <= 1'b0;
				end else if (pending.size() > 0) begin
					angles_t nxt;
					nxt = pending[0];
					angles.valid <= 1'b1;
					angles.roll_angle <= nxt.roll;
					angles.pitch_angle <= nxt.pitch;
					angles.yaw_angle <= nxt.yaw;
					if (burst > 0) begin
						burst <= burst - 1;
					end else begin
						burst <= $urandom_range(0, 40);
						gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					angles.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix.ready <= 1'b0;
			stall_mode <= 0;
			stall_cnt <= 0;
		end else begin
			if (matrix.valid && matrix.ready) begin
				matrix_t got, exp;
				got = {matrix.m00, matrix.m01, matrix.m02, matrix.m10, matrix.m11,
					matrix.m12, matrix.m20, matrix.m21, matrix.m22};
				if (expected.size() == 0) begin
					$error("matrix item with nothing expected");
					errors = errors + 1;
				end else begin
					exp = expected.pop_front();
					checked = checked + 1;
					if (got.m00 !== exp.m00) begin $error("m00 exp %h got %h", exp.m00, got.m00); errors++; end
					if (got.m01 !== exp.m01) begin $error("m01 exp %h got %h", exp.m01, got.m01); errors++; end
					if (got.m02 !== exp.m02) begin $error("m02 exp %h got %h", exp.m02, got.m02); errors++; end
					if (got.m10 !== exp.m10) begin $error("m10 exp %h got %h", exp.m10, got.m10); errors++; end
					if (got.m11 !== exp.m11) begin $error("m11 exp %h got %h", exp.m11, got.m11); errors++; end
					if (got.m12 !== exp.m12) begin $error("m12 exp %h got %h", exp.m12, got.m12); errors++; end
					if (got.m20 !== exp.m20) begin $error("m20 exp %h got %h", exp.m20, got.m20); errors++; end
					if (got.m21 !== exp.m21) begin $error("m21 exp %h got %h", exp.m21, got.m21); errors++; end
					if (got.m22 !== exp.m22) begin $error("m22 exp %h got %h", exp.m22, got.m22); errors++; end
				end
			end
			if (stall_cnt == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_cnt <= $urandom_range(5, 60);
			end else begin
				stall_cnt <= stall_cnt - 1;
			end
			case (stall_mode)
				0: matrix.ready <= 1'b1;
				1: matrix.ready <= ($urandom_range(0, 3) != 0);
				2: matrix.ready <= 1'($urandom_range(0, 1));
				default: matrix.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	initial begin
		logic [15:0] corner[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
			16'h7fff, 16'hffff, 16'h2000, 16'h0001};
		for (int i = 0; i < 8; i++)
			pending.insert(pending.size(), {corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]});
		pending.insert(pending.size(), {16'h0000, 16'h4000, 16'h0000});
		pending.insert(pending.size(), {16'h0000, 16'hc000, 16'h0000});
		pending.insert(pending.size(), {16'h2000, 16'h2000, 16'h2000});
		pending.insert(pending.size(), {16'ha000, 16'h6000, 16'he000});
		pending.insert(pending.size(), {16'h5555, 16'haaaa, 16'h3333});
		pending.insert(pending.size(), {16'haaaa, 16'h5555, 16'hcccc});
		for (int i = 0; i < 650; i++)
			pending.insert(pending.size(), {pick_angle(), pick_angle(), pick_angle()});
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending.size() == 0);
		wait (expected.size() == 0);
		repeat (3 * LAT) @(posedge clk);
		$display("checked %0d rotation matrices from corner and random angle triples", checked);
		$display("with bursty input and varied output back-pressure");
		if (errors == 0 && expected.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
